### hdl/ising_lattice_energy_magnetization_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Ising lattice energy and magnetisation unit
// Shorthand for clocked implication checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef ISING_LATTICE_ENERGY_MAGNETIZATION_UNIT_MACROS_SVH
`define ISING_LATTICE_ENERGY_MAGNETIZATION_UNIT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ILEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ILEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ilem_pkg.sv
// ----------------------------------------------------------------------------
// ilem_pkg
// Field widths, payload types and fixed constants of the lattice unit.
// ----------------------------------------------------------------------------
package ilem_pkg;

  localparam int SPIN_W     = 14;  // total spin field
  localparam int ENERGY_W   = 15;  // total energy field
  localparam int CFG_W      = 7;   // side length register
  localparam int SIDE_MIN   = 2;   // smallest usable side
  localparam int SIDE_RESET = 32;  // side after reset, before clamping
  localparam int JOB_DEPTH  = 2;   // entries in the front-to-back job queue

  typedef logic signed [SPIN_W-1:0]   total_spin_t;
  typedef logic signed [ENERGY_W-1:0] total_energy_t;
  typedef logic [CFG_W-1:0]           side_cfg_t;

endpackage

### hdl/ilem_if.sv
// ----------------------------------------------------------------------------
// ilem channel interfaces
// Valid/ready channels for spins in, sums out and the side length register.
// ----------------------------------------------------------------------------
interface ilem_in_if;
  logic valid;
  logic ready;
  logic spin;
  logic last;

  modport source (output valid, output spin, output last, input ready);
  modport sink   (input valid, input spin, input last, output ready);
endinterface

interface ilem_out_if;
  logic                 valid;
  logic                 ready;
  ilem_pkg::total_spin_t   total_spin;
  ilem_pkg::total_energy_t total_energy;

  modport source (output valid, output total_spin, output total_energy, input ready);
  modport sink   (input valid, input total_spin, input total_energy, output ready);
endinterface

interface ilem_cfg_if;
  logic                valid;
  logic                ready;
  ilem_pkg::side_cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/ising_lattice_energy_magnetization_unit.sv
// ----------------------------------------------------------------------------
// ising_lattice_energy_magnetization_unit
// Total spin and periodic bond energy of a square Ising lattice.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  : write the side length L (clamped to 2..MAX_SIDE); write only
//             while no frame is in flight. Reset value is 32.
//   in_ch   : one spin per transfer in row-major order, last on the final
//             site. Spins past L*L are dropped, neither stored nor summed.
//   out_ch  : one transfer per frame with total_spin and total_energy.
// Timing:
//   Spins load at one per cycle while input is not held off. After the
//   last transfer the back end walks the store one site per cycle through
//   two read ports in a single pass over the spin store, and the result
//   register loads once that pass is done. Input is held off while a frame
//   waits for or runs its scan.
// Reset:
//   Clears the input and queue counters, the spin sum, the job queue and
//   the result valid flag. The spin store is not cleared; every site must
//   be written before it is measured.
// Stall:
//   A result waiting on out_ch does not stop loading of the next frame;
//   its scan starts once the result register has drained.
// ----------------------------------------------------------------------------
module ising_lattice_energy_magnetization_unit #(
  parameter int MAX_SIDE = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ilem_in_if.sink   in_ch,
  ilem_cfg_if.sink  cfg_ch,
  ilem_out_if.source out_ch
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  // front/back hand-off
  logic                  job_push;
  logic                  job_pop;
  logic                  job_empty;
  ilem_pkg::total_spin_t job_wdata;
  ilem_pkg::total_spin_t job_rdata;
  logic                  back_busy;
  logic [SIDE_W-1:0]     side;

  // spin store ports
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr_a;
  logic [ADDR_W-1:0]     ram_raddr_b;
  logic                  ram_rdata_a;
  logic                  ram_rdata_b;

  // front end: config, spin loading, running spin sum
  ilem_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .back_busy (back_busy),
    .job_empty (job_empty),
    .job_push  (job_push),
    .job_data  (job_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .side      (side)
  );

  // finished frames wait here for the scan
  ilem_job_fifo u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_wdata),
    .pop       (job_pop),
    .pop_data  (job_rdata),
    .empty     (job_empty)
  );

  // spin store: port A reads the site, port B the site below it
  ilem_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_spin_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // back end: energy scan and result register
  ilem_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .side        (side),
    .job_empty   (job_empty),
    .job_data    (job_rdata),
    .job_pop     (job_pop),
    .busy        (back_busy),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b),
    .out_ch      (out_ch)
  );

endmodule

### hdl/ilem_ram.sv
// ----------------------------------------------------------------------------
// ilem_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ilem_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/ilem_job_fifo.sv
// ----------------------------------------------------------------------------
// ilem_job_fifo
// Short queue of finished frames (their total spin) from front to back.
// ----------------------------------------------------------------------------
module ilem_job_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ilem_pkg::total_spin_t push_data,
  input  logic                  pop,
  output ilem_pkg::total_spin_t pop_data,
  output logic                  empty
);

  localparam int PW = $clog2(ilem_pkg::JOB_DEPTH);
  localparam int CW = $clog2(ilem_pkg::JOB_DEPTH + 1);

  ilem_pkg::total_spin_t entry_r [ilem_pkg::JOB_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = entry_r[rd_ptr_r];
  assign empty    = (count_r == '0);

endmodule

### hdl/ilem_front.sv
// ----------------------------------------------------------------------------
// ilem_front
// Load spins into the store, keep the running spin sum, queue a frame on last.
// ----------------------------------------------------------------------------
module ilem_front #(
  parameter int MAX_SIDE = 64,
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
  localparam int ADDR_W  = $clog2(DEPTH),
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ilem_in_if.sink               in_ch,
  ilem_cfg_if.sink              cfg_ch,
  input  logic                  back_busy,
  input  logic                  job_empty,
  output logic                  job_push,
  output ilem_pkg::total_spin_t job_data,
  output logic                  ram_we,
  output logic [ADDR_W-1:0]     ram_waddr,
  output logic                  ram_wdata,
  output logic [SIDE_W-1:0]     side
);

  localparam int CNT_W  = ADDR_W + 1;
  localparam int PROD_W = 2 * SIDE_W;
  localparam int CMP_W  = (SIDE_W > ilem_pkg::CFG_W) ? SIDE_W : ilem_pkg::CFG_W;
  localparam int RST_SIDE  = (ilem_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                               : ilem_pkg::SIDE_RESET;
  localparam int RST_SITES = RST_SIDE * RST_SIDE;

  logic [SIDE_W-1:0]     side_r, side_nxt;
  logic [CNT_W-1:0]      sites_r, sites_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  ilem_pkg::total_spin_t spin_sum_r, spin_sum_nxt;

  logic [CMP_W-1:0]      cfg_ext;
  logic [SIDE_W-1:0]     side_clamp;
  logic [PROD_W-1:0]     side_sq;
  logic                  cfg_take;
  logic                  in_take;
  logic                  in_range;
  ilem_pkg::total_spin_t spin_upd;

  // clamp the written side into the usable range, then square it
  always_comb begin
    cfg_ext = CMP_W'(cfg_ch.data);
    if (cfg_ext < CMP_W'(ilem_pkg::SIDE_MIN)) begin
      side_clamp = SIDE_W'(ilem_pkg::SIDE_MIN);
    end else if (cfg_ext > CMP_W'(MAX_SIDE)) begin
      side_clamp = SIDE_W'(MAX_SIDE);
    end else begin
      side_clamp = SIDE_W'(cfg_ext);
    end
    side_sq = PROD_W'(side_clamp) * PROD_W'(side_clamp);
  end

  assign cfg_ch.ready = 1'b1;
  assign cfg_take     = cfg_ch.valid && cfg_ch.ready;

  // hold input while a frame waits for or occupies the store scan
  assign in_ch.ready = job_empty && !back_busy;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign in_range    = (count_r < sites_r);

  assign spin_upd  = in_range ? spin_sum_r + {{(ilem_pkg::SPIN_W-1){~in_ch.spin}}, 1'b1}
                              : spin_sum_r;

  assign ram_we    = in_take && in_range;
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_wdata = in_ch.spin;
  assign job_push  = in_take && in_ch.last;
  assign job_data  = spin_upd;
  assign side      = side_r;

  always_comb begin
    side_nxt     = side_r;
    sites_nxt    = sites_r;
    count_nxt    = count_r;
    spin_sum_nxt = spin_sum_r;
    if (cfg_take) begin
      side_nxt  = side_clamp;
      sites_nxt = CNT_W'(side_sq);
    end
    if (in_take) begin
      if (in_ch.last) begin
        count_nxt    = '0;
        spin_sum_nxt = '0;
      end else begin
        spin_sum_nxt = spin_upd;
        if (count_r != CNT_W'(DEPTH)) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= SIDE_W'(RST_SIDE);
      sites_r    <= CNT_W'(RST_SITES);
      count_r    <= '0;
      spin_sum_r <= '0;
    end else begin
      side_r     <= side_nxt;
      sites_r    <= sites_nxt;
      count_r    <= count_nxt;
      spin_sum_r <= spin_sum_nxt;
    end
  end

endmodule

### hdl/ilem_back.sv
// ----------------------------------------------------------------------------
// ilem_back
// Scan the spin store once per frame, sum bond energies, register the result.
// ----------------------------------------------------------------------------
`include "ising_lattice_energy_magnetization_unit_macros.svh"

module ilem_back #(
  parameter int MAX_SIDE = 64,
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
  localparam int ADDR_W  = $clog2(DEPTH),
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SIDE_W-1:0]     side,
  input  logic                  job_empty,
  input  ilem_pkg::total_spin_t job_data,
  output logic                  job_pop,
  output logic                  busy,
  output logic [ADDR_W-1:0]     ram_raddr_a,
  output logic [ADDR_W-1:0]     ram_raddr_b,
  input  logic                  ram_rdata_a,
  input  logic                  ram_rdata_b,
  ilem_out_if.source            out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam int EW = ilem_pkg::ENERGY_W;

  logic [1:0]              state_r, state_nxt;
  logic [SIDE_W-1:0]       col_r, col_nxt;
  logic [SIDE_W-1:0]       row_r, row_nxt;
  logic [ADDR_W-1:0]       cur_addr_r, cur_addr_nxt;
  logic [ADDR_W-1:0]       down_addr_r, down_addr_nxt;
  ilem_pkg::total_spin_t   spin_r, spin_nxt;
  ilem_pkg::total_energy_t energy_r, energy_nxt;
  logic                    v1_r, v1_nxt;
  logic                    first1_r, first1_nxt;
  logic                    end1_r, end1_nxt;
  logic                    fin1_r, fin1_nxt;
  logic                    prev_r, prev_nxt;
  logic                    rowfirst_r, rowfirst_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ilem_pkg::total_spin_t   out_spin_r, out_spin_nxt;
  ilem_pkg::total_energy_t out_energy_r, out_energy_nxt;

  logic [SIDE_W-1:0]       side_last;
  logic                    col_end;
  logic                    row_last;
  logic signed [2:0]       d_down, d_right, d_wrap, delta;
  ilem_pkg::total_energy_t energy_sum;

  assign side_last = side - SIDE_W'(1);
  assign col_end   = (col_r == side_last);
  assign row_last  = (row_r == side_last);

  // each bond adds +1 when its spins differ and -1 when they agree
  always_comb begin
    d_down  = (ram_rdata_a ^ ram_rdata_b) ? 3'sd1 : -3'sd1;
    d_right = first1_r ? 3'sd0 : ((prev_r ^ ram_rdata_a) ? 3'sd1 : -3'sd1);
    d_wrap  = !end1_r ? 3'sd0 : ((rowfirst_r ^ ram_rdata_a) ? 3'sd1 : -3'sd1);
    delta   = d_down + d_right + d_wrap;
    energy_sum = energy_r + {{(EW-3){delta[2]}}, delta};
  end

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    cur_addr_nxt   = cur_addr_r;
    down_addr_nxt  = down_addr_r;
    spin_nxt       = spin_r;
    energy_nxt     = energy_r;
    v1_nxt         = 1'b0;
    first1_nxt     = first1_r;
    end1_nxt       = end1_r;
    fin1_nxt       = 1'b0;
    prev_nxt       = prev_r;
    rowfirst_nxt   = rowfirst_r;
    out_valid_nxt  = out_valid_r;
    out_spin_nxt   = out_spin_r;
    out_energy_nxt = out_energy_r;
    job_pop        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // read data of the site issued last cycle
    if (v1_r) begin
      energy_nxt = energy_sum;
      prev_nxt   = ram_rdata_a;
      if (first1_r) begin
        rowfirst_nxt = ram_rdata_a;
      end
      if (fin1_r) begin
        out_valid_nxt  = 1'b1;
        out_spin_nxt   = spin_r;
        out_energy_nxt = energy_sum;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty && !out_valid_r) begin
          job_pop       = 1'b1;
          spin_nxt      = job_data;
          energy_nxt    = '0;
          col_nxt       = '0;
          row_nxt       = '0;
          cur_addr_nxt  = '0;
          down_addr_nxt = ADDR_W'(side);
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        v1_nxt       = 1'b1;
        first1_nxt   = (col_r == '0);
        end1_nxt     = col_end;
        fin1_nxt     = col_end && row_last;
        cur_addr_nxt = cur_addr_r + ADDR_W'(1);
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_r + SIDE_W'(1);
          // the row before the last looks down onto row zero next
          if (row_r == side - SIDE_W'(2)) begin
            down_addr_nxt = '0;
          end else begin
            down_addr_nxt = down_addr_r + ADDR_W'(1);
          end
          if (row_last) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          col_nxt       = col_r + SIDE_W'(1);
          down_addr_nxt = down_addr_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      fin1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      fin1_r      <= fin1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    cur_addr_r   <= cur_addr_nxt;
    down_addr_r  <= down_addr_nxt;
    spin_r       <= spin_nxt;
    energy_r     <= energy_nxt;
    first1_r     <= first1_nxt;
    end1_r       <= end1_nxt;
    prev_r       <= prev_nxt;
    rowfirst_r   <= rowfirst_nxt;
    out_spin_r   <= out_spin_nxt;
    out_energy_r <= out_energy_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign ram_raddr_a  = cur_addr_r;
  assign ram_raddr_b  = down_addr_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.total_spin   = out_spin_r;
  assign out_ch.total_energy = out_energy_r;

  `ILEM_ASSERT_IMP(a_scan_in_bounds, clk, rst_n, state_r == ST_SCAN,
                   (col_r < side) && (row_r < side), "scan position outside lattice")
  `ILEM_ASSERT_IMP(a_scan_out_empty, clk, rst_n, state_r == ST_SCAN,
                   !out_valid_r, "result register occupied during scan")
  `ILEM_ASSERT_IMP(a_fin_in_drain, clk, rst_n, fin1_r,
                   v1_r && (state_r == ST_DRAIN), "final site seen outside drain")
  `ILEM_ASSERT_NXT(a_fin_loads_out, clk, rst_n, fin1_r,
                   out_valid_r, "finished scan did not load result")

endmodule
